[design/rtpg_pkg.sv]
package rtpg_pkg;

   // Register file layout
   localparam int CSR_DATA_W  = 13;
   localparam int CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_MODE = 2'd2;

   localparam logic [CSR_DATA_W-1:0] FRAME_WIDTH_RESET  = 13'd1024;
   localparam logic [CSR_DATA_W-1:0] FRAME_HEIGHT_RESET = 13'd768;
   localparam logic                  PATTERN_MODE_RESET = 1'b1;

   localparam logic MODE_GRID     = 1'b0;
   localparam logic MODE_GRADIENT = 1'b1;

   // Pixel fields
   localparam int COLOR_W = 8;
   localparam int PIX_W   = 12;
   localparam logic [COLOR_W-1:0] COLOR_MAX = 8'd255;

   // Gradient scale factors as shifts: y*256 and (x+y)*64
   localparam int BLUE_SHIFT = 8;
   localparam int RED_SHIFT  = 6;

   // Quotients are known to fit in COLOR_W bits once saturation is ruled out
   localparam int DIV_STEPS  = COLOR_W;
   localparam int STEP_W     = $clog2(DIV_STEPS);

   typedef struct packed {
      logic start;   // latch the accepted item and set up the dividers
      logic step;    // one quotient bit for both dividers
      logic load;    // move the finished pixel into the output register
   } rtpg_cmd_type;

   typedef struct packed {
      logic div_done;  // the current step produces the last quotient bit
   } rtpg_status_type;

endpackage

[design/rtpg_ctrl.sv]
module rtpg_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output rtpg_pkg::rtpg_cmd_type   cmd,
   input  rtpg_pkg::rtpg_status_type status
);
   import rtpg_pkg::*;

   localparam logic [1:0] ST_IDLE    = 2'd0;
   localparam logic [1:0] ST_DIVIDE  = 2'd1;
   localparam logic [1:0] ST_DELIVER = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in   = state_ff;
      cmd.start  = 1'b0;
      cmd.step   = 1'b0;
      cmd.load   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            cmd.step = 1'b1;
            if (status.div_done) begin
               state_in = ST_DELIVER;
            end
         end
         ST_DELIVER: begin
            if (out_free) begin
               cmd.load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // A pending pixel is never overwritten by a new one.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (!rsp_valid_ff || rsp_ready))
      else $error("output register loaded while a pixel is still pending");

   a_start_divides: assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> (state_ff == ST_DIVIDE))
      else $error("accepted item did not enter the divide phase");

   a_done_delivers: assert property (@(posedge clock) disable iff (reset)
      (cmd.step && status.div_done) |=> (state_ff == ST_DELIVER))
      else $error("last quotient step not followed by delivery");

   a_load_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> rsp_valid_ff)
      else $error("loaded pixel not presented on the result channel");

endmodule

[design/rtpg_datapath.sv]
module rtpg_datapath #(
   parameter int COORD_BITS = 12
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [rtpg_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [rtpg_pkg::CSR_DATA_W-1:0]      csr_write_data,
   input  logic                                 req_restart,
   input  rtpg_pkg::rtpg_cmd_type               cmd,
   output rtpg_pkg::rtpg_status_type            status,
   output logic [rtpg_pkg::COLOR_W-1:0]         rsp_blue,
   output logic [rtpg_pkg::COLOR_W-1:0]         rsp_green,
   output logic [rtpg_pkg::COLOR_W-1:0]         rsp_red,
   output logic [rtpg_pkg::PIX_W-1:0]           rsp_pixel_x,
   output logic [rtpg_pkg::PIX_W-1:0]           rsp_pixel_y,
   output logic                                 rsp_line_end,
   output logic                                 rsp_frame_end
);
   import rtpg_pkg::*;

   localparam int SIZE_W  = COORD_BITS + 1;
   localparam int CLAMP_W = (CSR_DATA_W > SIZE_W) ? CSR_DATA_W : SIZE_W;
   localparam int SUM_W   = COORD_BITS + 2;
   localparam int REM_W   = COORD_BITS + 9;
   localparam logic [CLAMP_W-1:0] SIZE_MAX = {{(CLAMP_W-1){1'b0}}, 1'b1} << COORD_BITS;
   localparam logic [CLAMP_W-1:0] SIZE_MIN = {{(CLAMP_W-1){1'b0}}, 1'b1};

   // Configuration registers
   logic [CSR_DATA_W-1:0] frame_width_ff, frame_height_ff;
   logic                  pattern_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
         pattern_mode_ff <= PATTERN_MODE_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_FRAME_WIDTH:  frame_width_ff  <= csr_write_data;
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_write_data;
            CSR_PATTERN_MODE: pattern_mode_ff <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   // Sizes in use, clamped to 1 .. 2^COORD_BITS
   logic [CLAMP_W-1:0] width_ext, height_ext, width_clamp, height_clamp;
   logic [SIZE_W-1:0]  width_use, height_use;

   always_comb begin
      width_ext  = CLAMP_W'(frame_width_ff);
      height_ext = CLAMP_W'(frame_height_ff);
      if (width_ext == '0) begin
         width_clamp = SIZE_MIN;
      end else if (width_ext > SIZE_MAX) begin
         width_clamp = SIZE_MAX;
      end else begin
         width_clamp = width_ext;
      end
      if (height_ext == '0) begin
         height_clamp = SIZE_MIN;
      end else if (height_ext > SIZE_MAX) begin
         height_clamp = SIZE_MAX;
      end else begin
         height_clamp = height_ext;
      end
      width_use  = width_clamp[SIZE_W-1:0];
      height_use = height_clamp[SIZE_W-1:0];
   end

   // Scan counters
   logic [COORD_BITS-1:0] column_ff, row_ff;
   logic [COORD_BITS-1:0] x_start, y_start;
   logic                  eol_start, eof_start;

   assign x_start   = req_restart ? '0 : column_ff;
   assign y_start   = req_restart ? '0 : row_ff;
   assign eol_start = {1'b0, x_start} >= (width_use - SIZE_W'(1));
   assign eof_start = eol_start && ({1'b0, y_start} >= (height_use - SIZE_W'(1)));

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= '0;
         row_ff    <= '0;
      end else if (cmd.start) begin
         if (eol_start) begin
            column_ff <= '0;
            row_ff    <= eof_start ? '0 : y_start + COORD_BITS'(1);
         end else begin
            column_ff <= x_start + COORD_BITS'(1);
            row_ff    <= y_start;
         end
      end
   end

   // Grid band: four horizontal bands at quarter heights
   logic [SIZE_W+1:0] h_ext, quarter1, quarter2, quarter3, y_ext;
   logic [1:0]        band;
   logic              grid_white;

   always_comb begin
      h_ext    = (SIZE_W+2)'(height_use);
      y_ext    = (SIZE_W+2)'(y_start);
      quarter1 = h_ext >> 2;
      quarter2 = (h_ext << 1) >> 2;
      quarter3 = (h_ext + (h_ext << 1)) >> 2;
      if (y_ext < quarter1) begin
         band = 2'd3;
      end else if (y_ext < quarter2) begin
         band = 2'd2;
      end else if (y_ext < quarter3) begin
         band = 2'd1;
      end else begin
         band = 2'd0;
      end
      grid_white = ~x_start[band];
   end

   // Gradient dividers. Saturation is decided up front; otherwise the quotient
   // fits in eight bits and is produced one bit per step, divisor moving right.
   logic [COORD_BITS:0]   xy_sum;
   logic [SUM_W-1:0]      wh_sum;
   logic                  blue_sat, red_sat;

   assign xy_sum   = (COORD_BITS+1)'(x_start) + (COORD_BITS+1)'(y_start);
   assign wh_sum   = SUM_W'(width_use) + SUM_W'(height_use);
   assign blue_sat = {1'b0, y_start} >= height_use;
   assign red_sat  = (SUM_W+2)'(xy_sum) >= {wh_sum, 2'b00};

   logic [REM_W-1:0]   blue_rem_ff, blue_div_ff, red_rem_ff, red_div_ff;
   logic [COLOR_W-1:0] blue_q_ff, red_q_ff;
   logic [STEP_W-1:0]  step_ff;
   logic               blue_ge, red_ge;

   assign blue_ge = blue_rem_ff >= blue_div_ff;
   assign red_ge  = red_rem_ff >= red_div_ff;
   assign status.div_done = (step_ff == STEP_W'(DIV_STEPS - 1));

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         blue_rem_ff <= REM_W'(y_start) << BLUE_SHIFT;
         blue_div_ff <= REM_W'(height_use) << (DIV_STEPS - 1);
         red_rem_ff  <= REM_W'(xy_sum) << RED_SHIFT;
         red_div_ff  <= REM_W'(wh_sum) << (DIV_STEPS - 1);
         step_ff     <= '0;
      end else if (cmd.step) begin
         if (blue_ge) begin
            blue_rem_ff <= blue_rem_ff - blue_div_ff;
         end
         if (red_ge) begin
            red_rem_ff <= red_rem_ff - red_div_ff;
         end
         blue_div_ff <= blue_div_ff >> 1;
         red_div_ff  <= red_div_ff >> 1;
         blue_q_ff   <= {blue_q_ff[COLOR_W-2:0], blue_ge};
         red_q_ff    <= {red_q_ff[COLOR_W-2:0], red_ge};
         step_ff     <= step_ff + STEP_W'(1);
      end
   end

   // Item context held through the divide phase
   logic [COORD_BITS-1:0] x_ff, y_ff;
   logic                  eol_ff, eof_ff, mode_ff, white_ff, blue_sat_ff, red_sat_ff;

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         x_ff        <= x_start;
         y_ff        <= y_start;
         eol_ff      <= eol_start;
         eof_ff      <= eof_start;
         mode_ff     <= pattern_mode_ff;
         white_ff    <= grid_white;
         blue_sat_ff <= blue_sat;
         red_sat_ff  <= red_sat;
      end
   end

   // Output register
   logic [COLOR_W-1:0] blue_in, green_in, red_in;
   logic [COLOR_W-1:0] blue_ff, green_ff, red_ff;
   logic [PIX_W-1:0]   pixel_x_ff, pixel_y_ff;
   logic               line_end_ff, frame_end_ff;

   always_comb begin
      if (mode_ff == MODE_GRADIENT) begin
         blue_in  = blue_sat_ff ? COLOR_MAX : blue_q_ff;
         green_in = '0;
         red_in   = red_sat_ff ? COLOR_MAX : red_q_ff;
      end else begin
         blue_in  = white_ff ? COLOR_MAX : '0;
         green_in = blue_in;
         red_in   = blue_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         blue_ff      <= blue_in;
         green_ff     <= green_in;
         red_ff       <= red_in;
         pixel_x_ff   <= PIX_W'(x_ff);
         pixel_y_ff   <= PIX_W'(y_ff);
         line_end_ff  <= eol_ff;
         frame_end_ff <= eof_ff;
      end
   end

   assign rsp_blue      = blue_ff;
   assign rsp_green     = green_ff;
   assign rsp_red       = red_ff;
   assign rsp_pixel_x   = pixel_x_ff;
   assign rsp_pixel_y   = pixel_y_ff;
   assign rsp_line_end  = line_end_ff;
   assign rsp_frame_end = frame_end_ff;

endmodule

[design/raster_test_pattern_generator.sv]
// Raster test pattern generator.
// Each transfer on the request channel (req_valid/req_ready, field req_restart)
// produces exactly one pixel transfer on the response channel (rsp_valid/
// rsp_ready) carrying blue, green, red, the pixel position and line-end and
// frame-end marks. Pixels come out in raster order; req_restart set to 1 moves
// the scan back to pixel 0,0 before that pixel is produced.
// The csr_ write port sets frame width, frame height and pattern mode; writes
// take effect from the next request and leave the scan position as it is.
// After a request transfer the two gradient dividers each produce one quotient
// bit per step over eight steps, and the finished pixel is then loaded into the
// output register, which drives rsp_valid. The block takes one request at a
// time and takes the next one in the cycle after the load, so the eight-step
// divider loop sets the pace of the pixels.
// A finished pixel waits in the output register while the receiver stalls; the
// next request is already taken and computed meanwhile, and it is held until
// the output register frees up.
// Synchronous reset restores the register defaults (1024 x 768, gradient mode)
// and returns the scan to pixel 0,0; no clearing pass is needed.
module raster_test_pattern_generator #(
   parameter int COORD_BITS = 12
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_enable,
   input  logic [rtpg_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [rtpg_pkg::CSR_DATA_W-1:0]   csr_write_data,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_restart,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [rtpg_pkg::COLOR_W-1:0]      rsp_blue,
   output logic [rtpg_pkg::COLOR_W-1:0]      rsp_green,
   output logic [rtpg_pkg::COLOR_W-1:0]      rsp_red,
   output logic [rtpg_pkg::PIX_W-1:0]        rsp_pixel_x,
   output logic [rtpg_pkg::PIX_W-1:0]        rsp_pixel_y,
   output logic                              rsp_line_end,
   output logic                              rsp_frame_end
);
   import rtpg_pkg::*;

   rtpg_cmd_type    cmd;
   rtpg_status_type status;

   // The controller sequences set-up, divide steps and output loading.
   rtpg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   // The datapath holds the registers, scan counters, dividers and output pixel.
   rtpg_datapath #(
      .COORD_BITS (COORD_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_restart      (req_restart),
      .cmd              (cmd),
      .status           (status),
      .rsp_blue         (rsp_blue),
      .rsp_green        (rsp_green),
      .rsp_red          (rsp_red),
      .rsp_pixel_x      (rsp_pixel_x),
      .rsp_pixel_y      (rsp_pixel_y),
      .rsp_line_end     (rsp_line_end),
      .rsp_frame_end    (rsp_frame_end)
   );

endmodule

[tb/sv/testbench.sv]
module testbench;
   import rtpg_pkg::*;

   // One emitted pixel as it appears on the response channel.
   typedef struct packed {
      logic [COLOR_W-1:0] blue;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] red;
      logic [PIX_W-1:0]   pixel_x;
      logic [PIX_W-1:0]   pixel_y;
      logic               line_end;
      logic               frame_end;
   } pixel_type;

   // Ways the receiver paces its ready signal. Each one lasts for a random
   // stretch of cycles, so the stall pattern is independent of the sender.
   typedef enum logic [1:0] {
      ALWAYS_READY,
      COIN_FLIP,
      PERIODIC_STALL,
      RARE_READY
   } rx_pace_type;

   // The register file has three registers; the fourth index is unused and
   // a write to it must leave every setting alone.
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_INDEX = 2'd3;
   localparam int unsigned MAX_FRAME_SIZE = 1 << PIX_W;
   localparam int unsigned RANDOM_ITEMS = 1650;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_write_data = '0;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic                   req_restart = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [COLOR_W-1:0]     rsp_blue;
   logic [COLOR_W-1:0]     rsp_green;
   logic [COLOR_W-1:0]     rsp_red;
   logic [PIX_W-1:0]       rsp_pixel_x;
   logic [PIX_W-1:0]       rsp_pixel_y;
   logic                   rsp_line_end;
   logic                   rsp_frame_end;

   // Restart flags waiting to be offered on the request channel, and the
   // pixels predicted for requests that have been transferred.
   logic      queued_restarts[$];
   pixel_type predicted_pixels[$];

   // Shadow copy of the generator's settings and scan position.
   logic [CSR_DATA_W-1:0] width_setting = FRAME_WIDTH_RESET;
   logic [CSR_DATA_W-1:0] height_setting = FRAME_HEIGHT_RESET;
   logic                  mode_setting = PATTERN_MODE_RESET;
   logic [PIX_W-1:0]      scan_col = '0;
   logic [PIX_W-1:0]      scan_row = '0;

   int error_count = 0;

   // Sender pacing state.
   int burst_left = 0;
   int gap_left = 0;

   // Receiver pacing state.
   rx_pace_type pace_mode = ALWAYS_READY;
   int          pace_left = 0;
   int          pace_tick = 0;

   raster_test_pattern_generator DUT (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_restart      (req_restart),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_blue         (rsp_blue),
      .rsp_green        (rsp_green),
      .rsp_red          (rsp_red),
      .rsp_pixel_x      (rsp_pixel_x),
      .rsp_pixel_y      (rsp_pixel_y),
      .rsp_line_end     (rsp_line_end),
      .rsp_frame_end    (rsp_frame_end)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // A register value of zero acts as one, and anything past the counter
   // range acts as the full range.
   function automatic int unsigned clamp_size(input logic [CSR_DATA_W-1:0] value);
      if (value == 0)
         return 1;
      if (value > MAX_FRAME_SIZE)
         return MAX_FRAME_SIZE;
      return 32'(value);
   endfunction

   // Gradient colors can overflow once the scan position lies past the frame.
   function automatic logic [COLOR_W-1:0] saturate(input int unsigned value);
      return (value > COLOR_MAX) ? COLOR_MAX : value[COLOR_W-1:0];
   endfunction

   // Works out the pixel that one request produces and advances the scan.
   function automatic pixel_type render_pixel(input logic restart);
      int unsigned cols;
      int unsigned rows;
      int unsigned x;
      int unsigned y;
      int unsigned band;
      pixel_type   pix;
      cols = clamp_size(width_setting);
      rows = clamp_size(height_setting);
      if (restart) begin
         scan_col = '0;
         scan_row = '0;
      end
      x = 32'(scan_col);
      y = 32'(scan_row);
      if (mode_setting == MODE_GRADIENT) begin
         pix.blue  = saturate((y << BLUE_SHIFT) / rows);
         pix.green = '0;
         pix.red   = saturate(((x + y) << RED_SHIFT) / (cols + rows));
      end else begin
         // Bands are numbered from three at the top down to zero at the bottom;
         // a higher band makes the vertical stripes wider.
         if (y < rows / 4)
            band = 3;
         else if (y < (rows * 2) / 4)
            band = 2;
         else if (y < (rows * 3) / 4)
            band = 1;
         else
            band = 0;
         pix.blue  = ((x >> band) & 1) == 0 ? COLOR_MAX : '0;
         pix.green = pix.blue;
         pix.red   = pix.blue;
      end
      pix.pixel_x = x[PIX_W-1:0];
      pix.pixel_y = y[PIX_W-1:0];
      // A column left past the frame edge by a shrinking size still ends its
      // line at once; a row left past it ends the frame at its next line end.
      pix.line_end  = x >= cols - 1;
      pix.frame_end = pix.line_end && (y >= rows - 1);
      if (pix.line_end) begin
         scan_col = '0;
         scan_row = pix.frame_end ? '0 : y[PIX_W-1:0] + 1'b1;
      end else begin
         scan_col = x[PIX_W-1:0] + 1'b1;
         scan_row = y[PIX_W-1:0];
      end
      return pix;
   endfunction

   function automatic void check_field(input string field, input logic [15:0] want,
                                       input logic [15:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d, got %0d", field, want, got);
         error_count++;
      end
   endfunction

   // Writes one register and updates the shadow copy. Callers make sure the
   // generator is idle, so no request can see a half-updated setting.
   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      case (index)
         CSR_FRAME_WIDTH:  width_setting = data;
         CSR_FRAME_HEIGHT: height_setting = data;
         CSR_PATTERN_MODE: mode_setting = data[0];
         default: ;
      endcase
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Holds the sender back until every queued request has been transferred
   // and every predicted pixel has come back. Polling on the falling edge
   // keeps the check clear of the updates made at the rising edge.
   task automatic drain_generator();
      do
         @(negedge clock);
      while (queued_restarts.size() != 0 || req_valid || predicted_pixels.size() != 0);
   endtask

   // Queues a run of requests. With a large restart_odds most runs are long
   // uninterrupted scans, which is what reaches line and frame ends.
   task automatic run_scan(input int count, input int restart_odds);
      repeat (count)
         queued_restarts.push_back($urandom_range(0, restart_odds - 1) == 0);
      drain_generator();
   endtask

   // Frame sizes are mostly small so that frames complete often; now and
   // then an edge value or a fully random 13-bit value is used.
   function automatic logic [CSR_DATA_W-1:0] pick_size();
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 4))
               0: return 13'd0;
               1: return 13'd1;
               2: return 13'd4096;
               3: return 13'd4097;
               default: return 13'h1FFF;
            endcase
         end
         1: return CSR_DATA_W'($urandom_range(0, 8191));
         default: return CSR_DATA_W'($urandom_range(1, 12));
      endcase
   endfunction

   // Sender: offers queued requests in bursts of random length separated by
   // random gaps. A request stays on the channel, unchanged, until its
   // transfer, at which point the expected pixel is predicted.
   always @(posedge clock) begin : drive_requests
      logic fire;
      fire = req_valid && req_ready;
      if (reset) begin
         req_valid   <= 1'b0;
         req_restart <= 1'b0;
         burst_left = 0;
         gap_left   = 0;
      end else begin
         if (fire)
            predicted_pixels.push_back(render_pixel(req_restart));
         if (!req_valid || fire) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (queued_restarts.size() != 0) begin
               req_valid   <= 1'b1;
               req_restart <= queued_restarts.pop_front();
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  // Some bursts run straight into the next one, so there are
                  // long stretches with the sender never idle.
                  burst_left = $urandom_range(0, 40);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: switches between pacing modes at random intervals, from always
   // ready to ready only now and then.
   always @(posedge clock) begin : pace_receiver
      if (reset) begin
         rsp_ready <= 1'b0;
         pace_mode = ALWAYS_READY;
         pace_left = 0;
         pace_tick = 0;
      end else begin
         if (pace_left == 0) begin
            pace_mode = rx_pace_type'($urandom_range(0, 3));
            pace_left = $urandom_range(40, 300);
         end else begin
            pace_left--;
         end
         pace_tick++;
         case (pace_mode)
            ALWAYS_READY:   rsp_ready <= 1'b1;
            COIN_FLIP:      rsp_ready <= $urandom_range(0, 1) == 1;
            PERIODIC_STALL: rsp_ready <= (pace_tick % 16) >= 11;
            default:        rsp_ready <= $urandom_range(0, 7) == 0;
         endcase
      end
   end

   // Monitor: every pixel transfer is matched against the oldest prediction.
   always @(posedge clock) begin : check_pixels
      pixel_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (predicted_pixels.size() == 0) begin
            $error("pixel transfer with no request outstanding");
            error_count++;
         end else begin
            want = predicted_pixels.pop_front();
            check_field("blue", 16'(want.blue), 16'(rsp_blue));
            check_field("green", 16'(want.green), 16'(rsp_green));
            check_field("red", 16'(want.red), 16'(rsp_red));
            check_field("pixel_x", 16'(want.pixel_x), 16'(rsp_pixel_x));
            check_field("pixel_y", 16'(want.pixel_y), 16'(rsp_pixel_y));
            check_field("line_end", 16'(want.line_end), 16'(rsp_line_end));
            check_field("frame_end", 16'(want.frame_end), 16'(rsp_frame_end));
         end
      end
   end

   initial begin : stimulus
      int  random_items;
      int  count;
      bit  tall_scan_done;
      random_items   = 0;
      tall_scan_done = 0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: a large gradient frame, with restarts at the first
      // pixel and in the middle of the line.
      queued_restarts = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0};
      drain_generator();

      // Zero sizes act as a 1 x 1 frame: every pixel ends both line and frame.
      // The unused register index is written with all ones and must be ignored.
      write_register(CSR_FRAME_WIDTH, 13'd0);
      write_register(CSR_FRAME_HEIGHT, 13'd0);
      write_register(CSR_PATTERN_MODE, CSR_DATA_W'(MODE_GRID));
      write_register(CSR_UNUSED_INDEX, 13'h1FFF);
      queued_restarts = '{1'b0, 1'b1, 1'b0};
      drain_generator();

      // Oversized width is clamped to the counter range; gradient colors.
      write_register(CSR_FRAME_WIDTH, 13'h1FFF);
      write_register(CSR_FRAME_HEIGHT, 13'd4096);
      write_register(CSR_PATTERN_MODE, CSR_DATA_W'(MODE_GRADIENT));
      queued_restarts = '{1'b1, 1'b0, 1'b0, 1'b0};
      drain_generator();

      // Shrinking to 2 x 4 leaves the column past the edge, so the next pixel
      // ends its line at once; the four rows then fall in the four bands.
      write_register(CSR_FRAME_WIDTH, 13'd2);
      write_register(CSR_FRAME_HEIGHT, 13'd4);
      write_register(CSR_PATTERN_MODE, CSR_DATA_W'(MODE_GRID));
      queued_restarts = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
      drain_generator();

      // Random phases. Every phase ends with the generator drained, which is
      // when the settings may change.
      while (random_items < RANDOM_ITEMS) begin
         if (!tall_scan_done && random_items > 600) begin
            // A one-pixel-wide, very tall frame walks the row counter far
            // down; the height then shrinks below the current row, so the
            // gradient saturates and the next line end is a frame end.
            tall_scan_done = 1;
            write_register(CSR_FRAME_WIDTH, 13'd1);
            write_register(CSR_FRAME_HEIGHT, 13'd4096);
            write_register(CSR_PATTERN_MODE, CSR_DATA_W'(MODE_GRADIENT));
            queued_restarts.push_back(1'b1);
            run_scan(250, 1000000);
            write_register(CSR_FRAME_HEIGHT, CSR_DATA_W'($urandom_range(2, 10)));
            run_scan(15, 1000000);
            random_items += 266;
         end else begin
            if ($urandom_range(0, 2) != 0)
               write_register(CSR_FRAME_WIDTH, pick_size());
            if ($urandom_range(0, 2) != 0)
               write_register(CSR_FRAME_HEIGHT, pick_size());
            if ($urandom_range(0, 1) != 0)
               write_register(CSR_PATTERN_MODE,
                              CSR_DATA_W'(($urandom_range(0, 7) == 0) ?
                              $urandom_range(0, 8191) : $urandom_range(0, 1)));
            if ($urandom_range(0, 9) == 0)
               write_register(CSR_UNUSED_INDEX, CSR_DATA_W'($urandom_range(0, 8191)));
            count = $urandom_range(10, 120);
            run_scan(count, ($urandom_range(0, 3) == 0) ? 4 : 60);
            random_items += count;
         end
      end

      // Let any stray pixel surface before the verdict.
      drain_generator();
      repeat (20) @(posedge clock);
      if (error_count == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

   // Guard against a hang: far beyond the slowest correct run.
   initial begin : watchdog
      #5000000;
      $display("testbench failed");
      $finish;
   end

endmodule

[raster_test_pattern_generator.f]
design/rtpg_pkg.sv
design/rtpg_ctrl.sv
design/rtpg_datapath.sv
design/raster_test_pattern_generator.sv
tb/sv/testbench.sv
